[hdl/pppoe_session_rx_filter_core_assert.svh]
// assertion macros for the pppoe session receive filter
// expects i_clk and i_rst_n in the scope of the module that uses them
`ifndef PPPOE_SESSION_RX_FILTER_CORE_ASSERT_SVH
`define PPPOE_SESSION_RX_FILTER_CORE_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define PRF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pppoe rx filter: same-cycle check failed");

// next-cycle implication, checked while out of reset
`define PRF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pppoe rx filter: next-cycle check failed");

`endif

[hdl/pppoe_rxf_pkg.sv]
// shared types and constants for the pppoe session receive filter
// no dependencies
`default_nettype none

package pppoe_rxf_pkg;

    // frame layout
    localparam int unsigned MAX_FRAME       = 1520;
    localparam int unsigned POS_W           = 11;
    localparam int unsigned ETH_HDR_BYTES   = 6 + 6 + 2;
    localparam int unsigned PPPOE_HDR_BYTES = 1 + 1 + 2 + 2;
    localparam int unsigned FULL_HDR_BYTES  = ETH_HDR_BYTES + PPPOE_HDR_BYTES;

    // header byte offsets
    localparam int unsigned OFS_ETYPE_HI   = 12;
    localparam int unsigned OFS_ETYPE_LO   = 13;
    localparam int unsigned OFS_CODE       = 15;
    localparam int unsigned OFS_SESSION_HI = 16;
    localparam int unsigned OFS_SESSION_LO = 17;
    localparam int unsigned OFS_LENGTH_HI  = 18;
    localparam int unsigned OFS_LENGTH_LO  = 19;

    localparam logic [7:0]  SESSION_CODE    = 8'h00;
    localparam logic [15:0] RESET_ETHERTYPE = 16'h8864;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_SESSION_ID         = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_ETHERTYPE = 2'd1;

    // result queue
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        VERDICT_ACCEPT   = 3'd0,
        VERDICT_SHORT    = 3'd1,
        VERDICT_ETYPE    = 3'd2,
        VERDICT_CODE     = 3'd3,
        VERDICT_SESSION  = 3'd4
    } t_verdict;

    // one result beat
    typedef struct packed {
        logic       is_status;
        logic [7:0] out_byte;
        t_verdict   verdict;
    } t_result;

    // what one accepted byte adds to the result queue
    typedef struct packed {
        logic       payload_vld;
        logic       status_vld;
        logic [7:0] payload_byte;
        t_verdict   verdict;
    } t_push;

endpackage

`default_nettype wire

[hdl/pppoe_rxf_parser.sv]
// per-byte header capture, payload select and verdict logic
// depends on pppoe_rxf_pkg
`default_nettype none

module pppoe_rxf_parser (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_take,
    input  wire logic [7:0]                i_rx_byte,
    input  wire logic                      i_frame_end,
    input  wire logic [15:0]               i_session_id,
    input  wire logic [15:0]               i_expected_ethertype,
    output pppoe_rxf_pkg::t_push           o_push
);
    import pppoe_rxf_pkg::*;

    logic [POS_W-1:0] r_pos,       n_pos;
    logic [15:0]      r_ethertype, n_ethertype;
    logic [7:0]       r_code,      n_code;
    logic [15:0]      r_session,   n_session;
    logic [15:0]      r_length,    n_length;

    logic             counted;
    logic [POS_W-1:0] payload_ofs;
    logic             payload_hit;
    t_verdict         verdict;

    always_comb begin
        counted     = r_pos < POS_W'(MAX_FRAME);
        n_pos       = counted ? r_pos + POS_W'(1) : r_pos;
        n_ethertype = r_ethertype;
        n_code      = r_code;
        n_session   = r_session;
        n_length    = r_length;
        if (counted) begin
            case (r_pos)
                POS_W'(OFS_ETYPE_HI):   n_ethertype = {i_rx_byte, r_ethertype[7:0]};
                POS_W'(OFS_ETYPE_LO):   n_ethertype = {r_ethertype[15:8], i_rx_byte};
                POS_W'(OFS_CODE):       n_code      = i_rx_byte;
                POS_W'(OFS_SESSION_HI): n_session   = {i_rx_byte, r_session[7:0]};
                POS_W'(OFS_SESSION_LO): n_session   = {r_session[15:8], i_rx_byte};
                POS_W'(OFS_LENGTH_HI):  n_length    = {i_rx_byte, r_length[7:0]};
                POS_W'(OFS_LENGTH_LO):  n_length    = {r_length[15:8], i_rx_byte};
                default: ;
            endcase
        end
        // payload window, the length field is already complete here
        payload_ofs = r_pos - POS_W'(FULL_HDR_BYTES);
        payload_hit = counted && (r_pos >= POS_W'(FULL_HDR_BYTES))
                      && (16'(payload_ofs) < r_length);
    end

    // verdict on the state as left by this byte
    always_comb begin
        if (n_pos < POS_W'(FULL_HDR_BYTES)) begin
            verdict = VERDICT_SHORT;
        end else if (17'(n_pos) < 17'(FULL_HDR_BYTES) + 17'(n_length)) begin
            verdict = VERDICT_SHORT;
        end else if (n_ethertype != i_expected_ethertype) begin
            verdict = VERDICT_ETYPE;
        end else if (n_code != SESSION_CODE) begin
            verdict = VERDICT_CODE;
        end else if (n_session != i_session_id) begin
            verdict = VERDICT_SESSION;
        end else begin
            verdict = VERDICT_ACCEPT;
        end
    end

    always_comb begin
        o_push.payload_vld  = i_take && payload_hit;
        o_push.status_vld   = i_take && i_frame_end;
        o_push.payload_byte = i_rx_byte;
        o_push.verdict      = verdict;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_frame_end)) begin
            r_pos       <= '0;
            r_ethertype <= '0;
            r_code      <= '0;
            r_session   <= '0;
            r_length    <= '0;
        end else if (i_take) begin
            r_pos       <= n_pos;
            r_ethertype <= n_ethertype;
            r_code      <= n_code;
            r_session   <= n_session;
            r_length    <= n_length;
        end
    end

endmodule

`default_nettype wire

[hdl/pppoe_rxf_result_queue.sv]
// small result queue, takes up to two results per cycle, gives one per cycle while popped
// depends on pppoe_rxf_pkg
`default_nettype none

module pppoe_rxf_result_queue (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire pppoe_rxf_pkg::t_push i_push,
    input  wire logic                 i_pop,
    output logic                      o_room,
    output logic                      o_valid,
    output pppoe_rxf_pkg::t_result    o_head
);
    import pppoe_rxf_pkg::*;

    t_result               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QUEUE_CW-1:0]   r_count,  n_count;

    logic [QUEUE_AW-1:0]   wr_ptr_nxt;
    logic [1:0]            push_cnt;
    logic                  pop_ok;
    t_result               first_entry;
    t_result               status_entry;

    always_comb begin
        status_entry.is_status = 1'b1;
        status_entry.out_byte  = 8'h00;
        status_entry.verdict   = i_push.verdict;
        if (i_push.payload_vld) begin
            first_entry.is_status = 1'b0;
            first_entry.out_byte  = i_push.payload_byte;
            first_entry.verdict   = VERDICT_ACCEPT;
        end else begin
            first_entry = status_entry;
        end
        push_cnt   = {1'b0, i_push.payload_vld} + {1'b0, i_push.status_vld};
        pop_ok     = i_pop && (r_count != '0);
        wr_ptr_nxt = r_wr_ptr + QUEUE_AW'(1);
        n_wr_ptr   = r_wr_ptr + QUEUE_AW'(push_cnt);
        n_rd_ptr   = pop_ok ? r_rd_ptr + QUEUE_AW'(1) : r_rd_ptr;
        n_count    = r_count + QUEUE_CW'(push_cnt) - QUEUE_CW'(pop_ok);
    end

    // need room for a payload beat and a verdict beat
    assign o_room  = r_count <= QUEUE_CW'(QUEUE_DEPTH - 2);
    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= first_entry;
        end
        if (push_cnt == 2'd2) begin
            r_mem[wr_ptr_nxt] <= status_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

[hdl/pppoe_session_rx_filter_core.sv]
// result beats are written into the registered queue and offered from its head
// throughput: one byte per cycle while ready; a frame's last byte can add a payload and
//   verdict beat, which the four-entry queue absorbs, draining one per out_ready cycle
// ready is low only while fewer than two queue entries are free
// reset (synchronous, active low) clears frame state and queue, session_id to 0 and
//   expected_ethertype to 0x8864
`default_nettype none

`include "pppoe_session_rx_filter_core_assert.svh"

module pppoe_session_rx_filter_core (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    // configuration writes
    input  wire logic                                  i_cfg_we,
    input  wire logic [pppoe_rxf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [pppoe_rxf_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // received frame bytes
    input  wire logic                                  i_rx_valid,
    output logic                                       o_rx_ready,
    input  wire logic [7:0]                            i_rx_byte,
    input  wire logic                                  i_frame_end,
    // payload and verdict beats
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic [7:0]                                 o_out_byte,
    output logic                                       o_is_status,
    output logic [2:0]                                 o_verdict,
    output logic                                       o_last
);
    import pppoe_rxf_pkg::*;

    // configuration registers
    logic [15:0] r_session_id;
    logic [15:0] r_expected_ethertype;

    logic    rx_take;
    t_push   push;
    t_result head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_session_id         <= '0;
            r_expected_ethertype <= RESET_ETHERTYPE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_SESSION_ID:         r_session_id         <= i_cfg_data;
                CFG_EXPECTED_ETHERTYPE: r_expected_ethertype <= i_cfg_data;
                default: ;  // writes past the register list are ignored
            endcase
        end
    end

    // a valid byte beat is taken whenever the queue can hold its worst case
    assign rx_take = i_rx_valid && o_rx_ready;

    // header capture and verdict, all in the cycle the byte arrives
    pppoe_rxf_parser u_parser (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_take               (rx_take),
        .i_rx_byte            (i_rx_byte),
        .i_frame_end          (i_frame_end),
        .i_session_id         (r_session_id),
        .i_expected_ethertype (r_expected_ethertype),
        .o_push               (push)
    );

    // results leave from registers, so the two sides stall independently
    pppoe_rxf_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (i_out_ready),
        .o_room  (o_rx_ready),
        .o_valid (o_out_valid),
        .o_head  (head)
    );

    assign o_out_byte  = head.out_byte;
    assign o_is_status = head.is_status;
    assign o_verdict   = head.verdict;
    // the verdict is always the closing beat of a frame
    assign o_last      = head.is_status;

    // checks
    `PRF_ASSERT_NEXT(a_end_gives_beat, rx_take && i_frame_end, o_out_valid)
    `PRF_ASSERT_NOW(a_empty_has_room, !o_out_valid, o_rx_ready)
    `PRF_ASSERT_NOW(a_status_byte_zero, o_out_valid && o_is_status, o_out_byte == 8'h00)
    `PRF_ASSERT_NOW(a_payload_clean, o_out_valid && !o_is_status, (o_verdict == VERDICT_ACCEPT) && !o_last)

endmodule

`default_nettype wire
